FILE: hw/rtl/twl_pkg.sv
// Trie word lookup: shared types, codes and helpers.
// Used by twl_ctrl, twl_datapath and trie_word_lookup_unit; no dependencies.
package twl_pkg;

    localparam int NODES_DEF       = 4096;
    localparam int MAX_LETTERS_DEF = 30;
    localparam int ALPHABET        = 26;

    // wide enough for any node count in range plus the "no child" values
    localparam int IDX_W      = 17;
    localparam int NODE_FLD_W = 12;
    localparam int SLOT_W     = 5;
    localparam int CHILD_W    = 13;
    localparam int CHAR_W     = 8;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 8;

    localparam logic [OP_W-1:0] OP_LOAD_CHILD = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_END   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

    localparam logic [STAT_W-1:0] RES_FOUND     = 2'd0;
    localparam logic [STAT_W-1:0] RES_MISS      = 2'd1;
    localparam logic [STAT_W-1:0] RES_NONLETTER = 2'd2;
    localparam logic [STAT_W-1:0] RES_NOT_READY = 2'd3;

    typedef enum logic [1:0] {
        FAIL_NONE,
        FAIL_PATH,
        FAIL_CHAR,
        FAIL_READY
    } fail_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_CHILD,
        S_ENDRD,
        S_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic child_upd;
        logic end_rd;
        logic finish;
    } twl_cmd_t;

    typedef struct packed {
        logic need_read;
        logic close;
        logic out_free;
    } twl_stat_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } letter_t;

    // case-folded letter slot of a raw character
    function automatic letter_t letter_of(input logic [CHAR_W-1:0] c);
        letter_t r;
        r.valid = 1'b0;
        r.slot  = '0;
        if (c inside {[8'h61:8'h7A]})
        begin
            r.valid = 1'b1;
            r.slot  = SLOT_W'(c - 8'h61);
        end
        else if (c inside {[8'h41:8'h5A]})
        begin
            r.valid = 1'b1;
            r.slot  = SLOT_W'(c - 8'h41);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/twl_ctrl.sv
// Trie word lookup: sequencing state machine.
// Depends on twl_pkg; drives twl_datapath through twl_cmd_t.
module twl_ctrl
    import twl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  twl_stat_t stat,
    output twl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.exec = 1'b1;
                if (stat.need_read)
                    state_next = S_CHILD;
                else if (stat.close)
                    state_next = S_ENDRD;
                else
                    state_next = S_IDLE;
            end
            S_CHILD:
            begin
                cmd.child_upd = 1'b1;
                state_next    = stat.close ? S_ENDRD : S_IDLE;
            end
            S_ENDRD:
            begin
                cmd.end_rd = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/twl_datapath.sv
// Trie word lookup: node table, end marks, walk state and result register.
// Depends on twl_pkg; commanded by twl_ctrl.
module twl_datapath
    import twl_pkg::*;
#(
    parameter int NODES       = NODES_DEF,
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  twl_cmd_t              cmd,
    output twl_stat_t             stat,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata
);

    localparam int NODE_W = $clog2(NODES);
    localparam int DEPTH  = NODES * ALPHABET;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LET_W  = $clog2(MAX_LETTERS + 1);

    // captured word
    logic [OP_W-1:0]       op_reg;
    logic [NODE_FLD_W-1:0] node_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [CHILD_W-1:0]    child_reg;
    logic                  endf_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;

    // walk state
    logic [NODE_W-1:0] cur_node_reg;
    logic [LET_W-1:0]  letters_reg;
    fail_t             failed_reg;
    logic              ready_reg;

    logic [CHILD_W-1:0] child_rd_reg;
    logic               end_rd_reg;

    logic                out_valid_reg;
    logic                out_word_reg;
    logic [STAT_W-1:0]   out_status_reg;

    logic [CHILD_W-1:0] child_mem [DEPTH];
    logic               end_mem   [NODES];

    letter_t           ltr;
    logic              is_query;
    logic              node_ok;
    logic              take_ok;
    logic [IDX_W-1:0]  child_ext;
    logic [NODE_W-1:0] sel_node;
    logic [SLOT_W-1:0] sel_slot;
    logic [ADDR_W-1:0] addr;
    logic              child_we;
    logic              end_we;
    logic              out_free;
    logic [STAT_W-1:0] res_status;

    assign ltr       = letter_of(char_reg);
    assign is_query  = (op_reg == OP_QUERY);
    assign node_ok   = (IDX_W'(node_reg) < IDX_W'(NODES));
    assign child_ext = IDX_W'(child_rd_reg);

    // character may advance the walk: ready, under the letter limit, not failed hard
    assign take_ok = ready_reg && (letters_reg < LET_W'(MAX_LETTERS))
                     && (failed_reg != FAIL_READY) && (failed_reg != FAIL_CHAR);

    assign sel_node = is_query ? cur_node_reg : NODE_W'(IDX_W'(node_reg));
    assign sel_slot = is_query ? ltr.slot : slot_reg;
    assign addr     = ADDR_W'(ADDR_W'(sel_node) * ADDR_W'(ALPHABET) + ADDR_W'(sel_slot));

    assign child_we = cmd.exec && (op_reg == OP_LOAD_CHILD) && node_ok
                      && (slot_reg < SLOT_W'(ALPHABET));
    assign end_we   = cmd.exec && (op_reg == OP_LOAD_END) && node_ok;

    assign out_free = !out_valid_reg || m_tready;

    assign stat.need_read = is_query && take_ok && ltr.valid && (failed_reg == FAIL_NONE);
    assign stat.close     = is_query && last_reg;
    assign stat.out_free  = out_free;

    always_comb
    begin
        if (!ready_reg || failed_reg == FAIL_READY)
            res_status = RES_NOT_READY;
        else if (failed_reg == FAIL_CHAR)
            res_status = RES_NONLETTER;
        else if (failed_reg == FAIL_PATH)
            res_status = RES_MISS;
        else if (end_rd_reg)
            res_status = RES_FOUND;
        else
            res_status = RES_MISS;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= s_tuser;
            node_reg  <= s_tdata[11:0];
            slot_reg  <= s_tdata[16:12];
            child_reg <= s_tdata[29:17];
            endf_reg  <= s_tdata[30];
            char_reg  <= s_tdata[38:31];
            last_reg  <= s_tlast;
        end
    end

    // node table: one port, write or registered read
    always_ff @(posedge clk)
    begin
        if (child_we)
            child_mem[addr] <= child_reg;
        if (cmd.exec && stat.need_read)
            child_rd_reg <= child_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (end_we)
            end_mem[sel_node] <= endf_reg;
        if (cmd.end_rd)
            end_rd_reg <= end_mem[cur_node_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ready_reg <= 1'b0;
        else if (cfg_we)
            ready_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_node_reg <= '0;
            letters_reg  <= '0;
            failed_reg   <= FAIL_NONE;
        end
        else if (cmd.finish)
        begin
            cur_node_reg <= '0;
            letters_reg  <= '0;
            failed_reg   <= FAIL_NONE;
        end
        else if (cmd.child_upd)
        begin
            if (child_ext >= IDX_W'(NODES))
                failed_reg <= FAIL_PATH;
            else
                cur_node_reg <= NODE_W'(child_ext);
        end
        else if (cmd.exec && is_query)
        begin
            if (!ready_reg)
                failed_reg <= FAIL_READY;
            else if (take_ok)
            begin
                if (!ltr.valid)
                    failed_reg <= FAIL_CHAR;
                else
                    letters_reg <= LET_W'(letters_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_word_reg   <= (res_status == RES_FOUND);
        end
    end

    // tdata: is_word [0], status [2:1]
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - STAT_W - 1)'(0), out_status_reg, out_word_reg};

    a_letter_limit: assert property (@(posedge clk) disable iff (!rst_n)
        letters_reg <= LET_W'(MAX_LETTERS))
        else $error("letter count past limit");

    a_walk_reset: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (cur_node_reg == '0) && (letters_reg == '0)
                       && (failed_reg == FAIL_NONE))
        else $error("walk state not cleared after result");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result overwrote an untaken result");

    a_word_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg == (out_status_reg == RES_FOUND)))
        else $error("is_word disagrees with status");

endmodule

FILE: hw/rtl/trie_word_lookup_unit.sv
// Trie word lookup: top level joining the controller and the datapath.
// Depends on twl_pkg, twl_ctrl and twl_datapath.
//
// Usage:
//   Slave channel s_*: one word per handshake. s_tuser is the operation
//   (load child pointer, load end mark, query character); s_tlast marks the
//   final character of a queried word. Loads fill the node table, queries
//   walk it from root node 0 one character at a time.
//   Master channel m_*: one result per word, sent after its last character.
//   Config: cfg_we/cfg_wdata set the dictionary-ready bit; clear, every
//   query answers not ready.
// Flow: one word at a time. A load or a character with no table read
//   is executed and done; a character that follows a child pointer also
//   takes a child-update state, the node table having a single port with
//   registered read data; a last character adds an end-mark read and result.
// Reset clears the walk state, the ready bit and the result valid flag; the
//   node table and end marks hold nothing valid until loaded.
// A stalled result sits in the output register; the next word is still
//   taken and only a following result waits for m_tready.
module trie_word_lookup_unit
    import twl_pkg::*;
#(
    parameter int NODES       = NODES_DEF,
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // node_index [11:0], letter_slot [16:12], child_value [29:17],
    // end_flag [30], char_code [38:31], zero [39]
    input  logic [S_DATA_W-1:0] s_tdata,
    // operation [1:0]
    input  logic [OP_W-1:0]     s_tuser,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // is_word [0], status [2:1], zero [7:3]
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    twl_cmd_t  cmd;
    twl_stat_t stat;

    twl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    twl_datapath #(
        .NODES       (NODES),
        .MAX_LETTERS (MAX_LETTERS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule
